/* sv/hmlf_pkg.sv */
// Package: request types, parse constants and helpers for the HTTP message length framer.
`timescale 1ns / 1ps
package hmlf_pkg;

  localparam int unsigned FieldLen = 15;
  localparam int unsigned EndLen   = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } hmlf_in_t;

  typedef struct packed {
    logic        complete;
    logic [31:0] message_length;
    logic [31:0] expected_length;
    logic        length_saturated;
  } hmlf_out_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_STOP   = 2'd2
  } number_phase_t;

  // lower-case field name, one character per match position
  function automatic logic [7:0] field_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // header terminator CR LF CR LF
  function automatic logic [7:0] end_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0, 3'd2: c = 8'h0d;
      3'd1, 3'd3: c = 8'h0a;
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

/* sv/http_message_length_framer.sv */
// Top level: request handshake, input register and result register around the parse core.
`timescale 1ns / 1ps
// HTTP message length framer. Feed one message byte per request, with first_byte set on
// the first byte of each message; every request yields one result telling whether header
// and body are complete, the byte count once complete, and the expected total length while
// the body is short. Sustained rate is one request per cycle while out_stall is low; a
// result passes through the input register, then the result register, once its request is
// taken. The rate is set by the update of the match counters and the LENGTH_BITS-wide
// length counters, all computed combinationally for each byte.
// Lengths are LENGTH_BITS wide internally and saturate; outputs carry the low 32 bits.
module http_message_length_framer
  import hmlf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hmlf_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hmlf_out_t out_data
);

  logic      in_v_r;
  hmlf_in_t  in_r;
  logic      out_v_r;
  hmlf_out_t out_r;
  hmlf_out_t res;
  logic      adv;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  hmlf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .item (in_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (adv) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_r <= in_data;
    if (adv) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

/* sv/hmlf_core.sv */
// Parse state and per-byte update: header end, Content-Length match, value and counters.
`timescale 1ns / 1ps
module hmlf_core
  import hmlf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  hmlf_in_t  item,
  output hmlf_out_t res
);

  localparam int unsigned W = LENGTH_BITS;
  localparam logic [W-1:0] LenMax = '1;
  localparam logic [3:0] FieldLenC = 4'(FieldLen);
  localparam logic [2:0] EndLenC = 3'(EndLen);

  logic [2:0]    ep_r, ep_nxt, ep_c;
  logic          hd_r, hd_nxt, hd_c;
  logic [3:0]    fp_r, fp_nxt, fp_c;
  logic          ff_r, ff_nxt, ff_c;
  number_phase_t ph_r, ph_nxt, ph_c;
  logic          neg_r, neg_nxt, neg_c;
  logic [W-1:0]  cv_r, cv_nxt, cv_c;
  logic [W-1:0]  bc_r, bc_nxt, bc_c;
  logic [W-1:0]  hl_r, hl_nxt, hl_c;
  logic          done_r, done_nxt, done_c;

  logic [7:0]    b, lc;
  logic          accum;
  logic [W+3:0]  prod;
  logic [W-1:0]  content_old;
  logic [W:0]    sum_w;
  logic [W-1:0]  sum;
  logic          sat;

  always_comb begin
    b  = item.data_byte;
    lc = ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;

    // a new message starts from cleared state
    if (item.first_byte) begin
      ep_c = '0; hd_c = 1'b0; fp_c = '0; ff_c = 1'b0; ph_c = NUM_SKIP;
      neg_c = 1'b0; cv_c = '0; bc_c = '0; hl_c = '0; done_c = 1'b0;
    end else begin
      ep_c = ep_r; hd_c = hd_r; fp_c = fp_r; ff_c = ff_r; ph_c = ph_r;
      neg_c = neg_r; cv_c = cv_r; bc_c = bc_r; hl_c = hl_r; done_c = done_r;
    end

    ep_nxt = ep_c; hd_nxt = hd_c; fp_nxt = fp_c; ff_nxt = ff_c; ph_nxt = ph_c;
    neg_nxt = neg_c; cv_nxt = cv_c; hl_nxt = hl_c;
    bc_nxt = (bc_c != LenMax) ? (bc_c + W'(1)) : bc_c;
    accum = 1'b0;

    prod = ({4'b0, cv_c} << 3) + ({4'b0, cv_c} << 1) + {{W{1'b0}}, b[3:0]};

    if (!hd_c) begin
      if (ff_c && (ph_c != NUM_STOP)) begin
        if (ph_c == NUM_SKIP) begin
          priority if (is_space(b)) begin
          end else if ((b == "+") || (b == "-")) begin
            neg_nxt = (b == "-");
            ph_nxt  = NUM_DIGITS;
          end else if (!is_digit(b)) begin
            ph_nxt = NUM_STOP;
          end else begin
            ph_nxt = NUM_DIGITS;
            accum  = 1'b1;
          end
        end else if (!is_digit(b)) begin
          ph_nxt = NUM_STOP;
        end else begin
          accum = 1'b1;
        end
        if (accum) begin
          cv_nxt = (prod > {4'b0, LenMax}) ? LenMax : prod[W-1:0];
        end
      end

      if (!ff_c) begin
        if ((fp_c < FieldLenC) && (lc == field_char(fp_c))) fp_nxt = fp_c + 4'd1;
        else fp_nxt = (lc == field_char(4'd0)) ? 4'd1 : 4'd0;
        if (fp_nxt >= FieldLenC) begin
          fp_nxt = FieldLenC;
          ff_nxt = 1'b1;
        end
      end

      if ((ep_c < EndLenC) && (b == end_char(ep_c))) ep_nxt = ep_c + 3'd1;
      else ep_nxt = (b == end_char(3'd0)) ? 3'd1 : 3'd0;
      if (ep_nxt >= EndLenC) begin
        ep_nxt = EndLenC;
        hd_nxt = 1'b1;
        hl_nxt = bc_nxt;
      end
    end

    // the header closes on LF, which never moves the value, so the value
    // held before this byte is the one that applies once the header is done
    content_old = neg_c ? '0 : cv_c;
    sum_w = {1'b0, hl_nxt} + {1'b0, content_old};
    sum   = sum_w[W] ? LenMax : sum_w[W-1:0];

    done_nxt = done_c;
    if (!done_c && hd_nxt && (!ff_nxt || ((bc_nxt - hl_nxt) >= content_old))) begin
      done_nxt = 1'b1;
    end

    sat = (bc_nxt == LenMax) || (ff_nxt && !neg_nxt && (cv_nxt == LenMax)) ||
          (hd_nxt && ff_nxt && (sum == LenMax));

    res.complete         = done_nxt;
    res.message_length   = done_nxt ? 32'(bc_nxt) : 32'd0;
    res.expected_length  = (hd_nxt && ff_nxt && !done_nxt) ? 32'(sum) : 32'd0;
    res.length_saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r <= '0; hd_r <= 1'b0; fp_r <= '0; ff_r <= 1'b0; ph_r <= NUM_SKIP;
      neg_r <= 1'b0; cv_r <= '0; bc_r <= '0; hl_r <= '0; done_r <= 1'b0;
    end else if (en) begin
      ep_r <= ep_nxt; hd_r <= hd_nxt; fp_r <= fp_nxt; ff_r <= ff_nxt; ph_r <= ph_nxt;
      neg_r <= neg_nxt; cv_r <= cv_nxt; bc_r <= bc_nxt; hl_r <= hl_nxt;
      done_r <= done_nxt;
    end
  end

  a_done_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> hd_r) else $error("complete without header end");

  a_header_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    hd_r |-> (ep_r == EndLenC)) else $error("header end without full terminator");

  a_field_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    ff_r |-> (fp_r == FieldLenC)) else $error("field found without full name");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !item.first_byte && done_r) |=> done_r) else $error("complete dropped");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (bc_r != '0)) else $error("byte count zero after a byte");

endmodule

/* sim/http_message_length_framer_tb.sv */
// Testbench for the HTTP message length framer: byte streams in, per-byte framing results checked.
`timescale 1ns / 1ps
module http_message_length_framer_tb
  import hmlf_pkg::*;
();

  localparam int                    LENGTH_BITS  = 32;
  localparam logic [63:0]           LEN_MAX      = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam logic [8*FieldLen-1:0] FIELD_NAME   = "content-length:";
  localparam logic [8*EndLen-1:0]   HDR_END      = 32'h0d0a0d0a;
  localparam logic [7:0]            CR           = 8'h0d;
  localparam logic [7:0]            LF           = 8'h0a;
  localparam int                    CYCLE_LIMIT  = 400000;
  localparam int                    DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  hmlf_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hmlf_out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  hmlf_out_t  predicted_frames[$];
  logic [7:0] msg_bytes[$];

  // framer state as seen by the predictor
  logic [2:0]    crlf_seen;
  logic          hdr_done;
  logic [3:0]    name_seen;
  logic          cl_found;
  number_phase_t num_phase;
  logic          num_neg;
  logic [63:0]   cl_value;
  logic [63:0]   byte_total;
  logic [63:0]   hdr_bytes;
  logic          msg_done;

  http_message_length_framer #(.LENGTH_BITS(LENGTH_BITS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_framer();
    crlf_seen  = '0;
    hdr_done   = 1'b0;
    name_seen  = '0;
    cl_found   = 1'b0;
    num_phase  = NUM_SKIP;
    num_neg    = 1'b0;
    cl_value   = '0;
    byte_total = '0;
    hdr_bytes  = '0;
    msg_done   = 1'b0;
  endfunction

  function automatic hmlf_out_t frame_byte(input hmlf_in_t req);
    logic [7:0]  b;
    logic [7:0]  lc;
    logic        is_dig;
    logic        is_ws;
    logic        sat;
    logic [63:0] content;
    logic [63:0] sum;
    logic [63:0] expected;
    hmlf_out_t   res;
    b        = req.data_byte;
    lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    is_dig   = b >= "0" && b <= "9";
    is_ws    = b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    expected = '0;
    if (req.first_byte) clear_framer();
    if (byte_total < LEN_MAX) byte_total++;
    if (!hdr_done) begin
      if (cl_found && num_phase != NUM_STOP && !(num_phase == NUM_SKIP && is_ws)) begin
        if (num_phase == NUM_SKIP && (b == "+" || b == "-")) begin
          num_neg   = b == "-";
          num_phase = NUM_DIGITS;
        end else if (!is_dig) begin
          num_phase = NUM_STOP;
        end else begin
          num_phase = NUM_DIGITS;
          cl_value  = cl_value * 10 + 64'(b - "0");
          if (cl_value > LEN_MAX) cl_value = LEN_MAX;
        end
      end
      if (!cl_found) begin
        if (name_seen < FieldLen && lc == FIELD_NAME[8*(FieldLen-1-name_seen) +: 8])
          name_seen++;
        else
          name_seen = (lc == FIELD_NAME[8*(FieldLen-1) +: 8]) ? 4'd1 : 4'd0;
        if (name_seen >= FieldLen) begin
          name_seen = 4'(FieldLen);
          cl_found  = 1'b1;
        end
      end
      if (crlf_seen < EndLen && b == HDR_END[8*(EndLen-1-crlf_seen) +: 8])
        crlf_seen++;
      else
        crlf_seen = (b == CR) ? 3'd1 : 3'd0;
      if (crlf_seen >= EndLen) begin
        crlf_seen = 3'(EndLen);
        hdr_done  = 1'b1;
        hdr_bytes = byte_total;
      end
    end
    content = num_neg ? 64'd0 : cl_value;
    if (!msg_done && hdr_done && (!cl_found || byte_total - hdr_bytes >= content))
      msg_done = 1'b1;
    sat = byte_total == LEN_MAX || (cl_found && content == LEN_MAX);
    if (hdr_done && cl_found) begin
      sum = hdr_bytes + content;
      if (sum > LEN_MAX) sum = LEN_MAX;
      if (sum == LEN_MAX) sat = 1'b1;
      if (!msg_done) expected = sum;
    end
    res.complete         = msg_done;
    res.message_length   = msg_done ? byte_total[31:0] : 32'd0;
    res.expected_length  = expected[31:0];
    res.length_saturated = sat;
    return res;
  endfunction

  // receiver: random stall, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    hmlf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_frames.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = predicted_frames.pop_front();
        if (out_data.complete !== want.complete) begin
          $display("%0t: complete expected %0d actual %0d", $time, want.complete,
                   out_data.complete);
          mismatches++;
        end
        if (out_data.message_length !== want.message_length) begin
          $display("%0t: message_length expected %0d actual %0d", $time,
                   want.message_length, out_data.message_length);
          mismatches++;
        end
        if (out_data.expected_length !== want.expected_length) begin
          $display("%0t: expected_length expected %0d actual %0d", $time,
                   want.expected_length, out_data.expected_length);
          mismatches++;
        end
        if (out_data.length_saturated !== want.length_saturated) begin
          $display("%0t: length_saturated expected %0d actual %0d", $time,
                   want.length_saturated, out_data.length_saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    hmlf_in_t req;
    req.data_byte  = b;
    req.first_byte = first;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_frames.push_back(frame_byte(req));
    @(negedge clk);
  endtask

  task automatic send_message(input logic fresh);
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], fresh && i == 0);
    msg_bytes.delete();
  endtask

  task automatic wait_for_results();
    while (predicted_frames.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_crlf();
    msg_bytes.push_back(CR);
    msg_bytes.push_back(LF);
  endtask

  task automatic add_space();
    case ($urandom_range(4))
      0: msg_bytes.push_back(" ");
      1: msg_bytes.push_back(8'h09);
      2: msg_bytes.push_back(8'h0b);
      3: msg_bytes.push_back(8'h0c);
      default: add_crlf();
    endcase
  endtask

  task automatic add_big_number();
    case ($urandom_range(3))
      0: add_text("4294967295");
      1: add_text("4294967290");
      2: add_text("4294967296");
      default: begin
        msg_bytes.push_back(8'("1" + $urandom_range(8)));
        repeat ($urandom_range(9, 12)) msg_bytes.push_back(8'("0" + $urandom_range(9)));
      end
    endcase
  endtask

  // mostly well-formed messages with random content; some noise, some cut short
  task automatic build_message(output logic fresh);
    int         kind;
    int         val;
    int         body_len;
    int         keep;
    logic       sized;
    logic [7:0] c;
    msg_bytes.delete();
    fresh = 1'b1;
    kind  = $urandom_range(9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(3) == 0) msg_bytes.push_back($urandom_range(1) ? CR : LF);
        else msg_bytes.push_back(8'($urandom_range(255)));
      end
      fresh = $urandom_range(1);
    end else begin
      add_text($urandom_range(1) ? "GET / HTTP/1.1" : "POST /a HTTP/1.1");
      add_crlf();
      repeat ($urandom_range(2)) begin
        add_text("X: ");
        msg_bytes.push_back(8'($urandom_range(32, 126)));
        add_crlf();
      end
      if ($urandom_range(3) == 0) begin
        add_text("Content-Type: t");
        add_crlf();
      end
      body_len = $urandom_range(6);
      if ($urandom_range(4) != 0) begin
        for (int i = FieldLen - 1; i >= 0; i--) begin
          c = FIELD_NAME[8*i +: 8];
          if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
          msg_bytes.push_back(c);
        end
        repeat ($urandom_range(2)) add_space();
        val   = $urandom_range(24);
        sized = 1'b1;
        case ($urandom_range(11))
          6: begin
            msg_bytes.push_back("+");
            add_text($sformatf("%0d", val));
          end
          7: begin
            msg_bytes.push_back("-");
            add_text($sformatf("%0d", val));
            sized = 1'b0;
          end
          8: sized = 1'b0;
          9: begin
            add_big_number();
            sized = 1'b0;
          end
          10: add_text($sformatf("%0dx9", val));
          11: add_text($sformatf("00%0d", val));
          default: add_text($sformatf("%0d", val));
        endcase
        add_crlf();
        if ($urandom_range(3) == 0) begin
          add_text("content-length: 99");
          add_crlf();
        end
        if (sized) begin
          case ($urandom_range(3))
            0: body_len = $urandom_range(val);
            1: body_len = val + $urandom_range(1, 3);
            default: body_len = val;
          endcase
        end
      end
      add_crlf();
      if ($urandom_range(5) == 0) add_text("Content-Length: 3");
      repeat (body_len) msg_bytes.push_back(8'($urandom_range(255)));
      if (kind == 1) begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end
    end
  endtask

  task automatic test_extremes();
    msg_bytes.push_back(8'h00);
    add_crlf();
    add_crlf();
    msg_bytes.push_back(8'hff);
    send_message(1'b1);
  endtask

  task automatic test_content_length();
    add_text("CONTENT-length:");
    msg_bytes.push_back(8'h09);
    add_text("2");
    add_crlf();
    add_crlf();
    add_text("ab");
    send_message(1'b1);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bytes);
    int   sent;
    logic fresh;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent          = 0;
    while (sent < n_bytes) begin
      build_message(fresh);
      sent += msg_bytes.size();
      send_message(fresh);
    end
  endtask

  task automatic test_receiver_holdoff();
    logic fresh;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 80;
    repeat (3) begin
      build_message(fresh);
      send_message(1'b1);
    end
  endtask

  task automatic test_sender_pause();
    logic fresh;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (4) begin
      build_message(fresh);
      send_message(fresh);
      in_valid <= 1'b0;
      wait_for_results();
    end
  endtask

  initial begin
    clear_framer();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_content_length();
    test_random_traffic(37, 86, 500);
    test_random_traffic(86, 37, 500);
    test_random_traffic(0, 0, 500);
    test_receiver_holdoff();
    test_sender_pause();
    recv_idle_pct = 0;
    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_frames.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
